[hdl/complex_arithmetic_unit_top_assert.svh]
// Assertion macros for the complex arithmetic unit checker.
// Needs nothing else; included by the checker file.
`ifndef COMPLEX_ARITHMETIC_UNIT_TOP_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CAU_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("complex arithmetic unit check failed");

// The consequent must hold in the cycle after the antecedent.
`define CAU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("complex arithmetic unit check failed");

`endif

[hdl/cau_pkg.sv]
// Shared constants, types and saturation helpers of the complex arithmetic unit.
// Depends on nothing; the design modules refer to it by scoped names.
package cau_pkg;

    localparam int FracBits = 16;
    // Quotient bits kept by the divider chain; anything at or above 2^QBits saturates.
    localparam int QBits    = 33;
    localparam int OvfShift = QBits - FracBits;

    localparam logic [2:0] CMD_ADD  = 3'd0;
    localparam logic [2:0] CMD_SUB  = 3'd1;
    localparam logic [2:0] CMD_MUL  = 3'd2;
    localparam logic [2:0] CMD_DIV  = 3'd3;
    localparam logic [2:0] CMD_CONJ = 3'd4;

    typedef struct packed {
        logic              is_div;
        logic              dz;
        logic [31:0]       res_re;
        logic [31:0]       res_im;
        logic              neg_re;
        logic              neg_im;
        logic              ovf_re;
        logic              ovf_im;
        logic [63:0]       rem_re;
        logic [63:0]       rem_im;
        logic [63:0]       den;
        logic [QBits-1:0]  dvd_re;
        logic [QBits-1:0]  dvd_im;
        logic [QBits-1:0]  q_re;
        logic [QBits-1:0]  q_im;
    } t_div_word;

    // Clamp a 33-bit signed sum to the 32-bit range.
    function automatic logic [31:0] sat33(input logic [32:0] x);
        logic [31:0] r;
        if (x[32] != x[31]) begin
            r = x[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    // Turn sign and magnitude into a saturated 32-bit two's complement value.
    function automatic logic [31:0] sat_mag(input logic neg, input logic [63:0] mag);
        logic [31:0] r;
        logic [63:0] n;
        n = 64'd0 - mag;
        if (neg) begin
            r = (mag >= 64'h8000_0000) ? 32'h8000_0000 : n[31:0];
        end else begin
            r = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
        end
        return r;
    endfunction

    // Sign and magnitude of a 65-bit signed value; the result is {neg, mag}.
    function automatic logic [64:0] sign_mag(input logic [64:0] s);
        logic [64:0] n;
        n = 65'd0 - s;
        return s[64] ? {1'b1, n[63:0]} : {1'b0, s[63:0]};
    endfunction

endpackage

[hdl/cau_if.sv]
// Valid/ready channel interfaces of the complex arithmetic unit.
// Depends on nothing.
interface cau_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         cmd;
    logic signed [31:0] a_re;
    logic signed [31:0] a_im;
    logic signed [31:0] b_re;
    logic signed [31:0] b_im;
    modport source (output valid, cmd, a_re, a_im, b_re, b_im, input ready);
    modport sink   (input valid, cmd, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] res_re;
    logic signed [31:0] res_im;
    logic               div_zero;
    modport source (output valid, res_re, res_im, div_zero, input ready);
    modport sink   (input valid, res_re, res_im, div_zero, output ready);
endinterface

[hdl/complex_arithmetic_unit_top.sv]
// Channel   | direction | payload
// i_in      | sink      | cmd, a_re, a_im, b_re, b_im
// o_out     | source    | res_re, res_im, div_zero
//
// The path runs through three front stages, 33 divider cells and an output register.
// A new word is taken every cycle, one word per cycle, as long as no stalled output backs up the chain.
// Every stage has its own valid bit and stalls only when it is full and the stage after
// it is blocked, so bubbles close up behind a stalled output.
// The reset is synchronous and active low and clears only the valid bits.
// Depends on cau_pkg, cau_if, cau_front and cau_div_cell.
module complex_arithmetic_unit_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    cau_in_if.sink       i_in,
    cau_out_if.source    o_out
);

    localparam int NCells = cau_pkg::QBits;

    // Valid, ready and word of every link in the chain; link 0 is the front's output.
    logic               w_v   [NCells+1];
    logic               w_rdy [NCells+1];
    cau_pkg::t_div_word w_word[NCells+1];

    logic               r_ov;
    logic               w_orly;
    logic [31:0]        r_res_re, r_res_im;
    logic               r_dz;
    logic [31:0]        n_res_re, n_res_im;
    cau_pkg::t_div_word w_last;
    logic [63:0]        w_mag_re, w_mag_im;

    cau_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_cmd   (i_in.cmd),
        .i_a_re  (i_in.a_re),
        .i_a_im  (i_in.a_im),
        .i_b_re  (i_in.b_re),
        .i_b_im  (i_in.b_im),
        .o_valid (w_v[0]),
        .i_ready (w_rdy[0]),
        .o_word  (w_word[0])
    );

    // Each cell settles one quotient bit, most significant first.
    for (genvar k = 0; k < NCells; k++) begin : g_cell
        cau_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_v[k]),
            .o_ready (w_rdy[k]),
            .i_word  (w_word[k]),
            .o_valid (w_v[k+1]),
            .i_ready (w_rdy[k+1]),
            .o_word  (w_word[k+1])
        );
    end

    assign w_orly        = !r_ov || o_out.ready;
    assign w_rdy[NCells] = w_orly;
    assign w_last        = w_word[NCells];

    // An overflowing quotient is given a magnitude that saturates in either sign.
    assign w_mag_re = w_last.ovf_re ? 64'h1_0000_0000 : 64'(w_last.q_re);
    assign w_mag_im = w_last.ovf_im ? 64'h1_0000_0000 : 64'(w_last.q_im);

    always_comb begin
        if (w_last.is_div) begin
            if (w_last.dz) begin
                n_res_re = '0;
                n_res_im = '0;
            end else begin
                n_res_re = cau_pkg::sat_mag(w_last.neg_re, w_mag_re);
                n_res_im = cau_pkg::sat_mag(w_last.neg_im, w_mag_im);
            end
        end else begin
            n_res_re = w_last.res_re;
            n_res_im = w_last.res_im;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_orly) begin
            r_ov <= w_v[NCells];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_orly && w_v[NCells]) begin
            r_res_re <= n_res_re;
            r_res_im <= n_res_im;
            r_dz     <= w_last.is_div && w_last.dz;
        end
    end

    assign o_out.valid    = r_ov;
    assign o_out.res_re   = r_res_re;
    assign o_out.res_im   = r_res_im;
    assign o_out.div_zero = r_dz;

endmodule

[hdl/cau_front.sv]
// Front of the unit: products, sums and divider set-up over three register stages.
// Depends on cau_pkg.
module cau_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [2:0]            i_cmd,
    input  logic signed [31:0]    i_a_re,
    input  logic signed [31:0]    i_a_im,
    input  logic signed [31:0]    i_b_re,
    input  logic signed [31:0]    i_b_im,
    output logic                  o_valid,
    input  logic                  i_ready,
    output cau_pkg::t_div_word    o_word
);

    logic w_rdy1, w_rdy2, w_rdy3;
    logic r_v1, r_v2, r_v3;

    logic [2:0]         r1_cmd;
    logic signed [31:0] r1_a, r1_b, r1_c, r1_d;
    logic signed [63:0] r1_ac, r1_bd, r1_ad, r1_bc, r1_cc, r1_dd;
    logic signed [63:0] w_ac, w_bd, w_ad, w_bc, w_cc, w_dd;

    cau_pkg::t_div_word r_w2, n_w2, r_w3, n_w3;

    logic [64:0] w_sm_mre, w_sm_mim, w_sm_dre, w_sm_dim;
    logic [64+cau_pkg::OvfShift:0] w_num_re_x, w_num_im_x, w_den_x;

    assign w_rdy3  = !r_v3 || i_ready;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;
    assign o_valid = r_v3;
    assign o_word  = r_w3;

    // One 32 by 32 multiplier per product, registered straight away.
    assign w_ac = i_a_re * i_b_re;
    assign w_bd = i_a_im * i_b_im;
    assign w_ad = i_a_re * i_b_im;
    assign w_bc = i_a_im * i_b_re;
    assign w_cc = i_b_re * i_b_re;
    assign w_dd = i_b_im * i_b_im;

    assign w_sm_mre = cau_pkg::sign_mag(65'(r1_ac) - 65'(r1_bd));
    assign w_sm_mim = cau_pkg::sign_mag(65'(r1_ad) + 65'(r1_bc));
    assign w_sm_dre = cau_pkg::sign_mag(65'(r1_ac) + 65'(r1_bd));
    assign w_sm_dim = cau_pkg::sign_mag(65'(r1_bc) - 65'(r1_ad));

    always_comb begin
        n_w2        = '0;
        n_w2.is_div = 1'b0;
        unique case (r1_cmd)
            cau_pkg::CMD_ADD: begin
                n_w2.res_re = cau_pkg::sat33(33'(r1_a) + 33'(r1_c));
                n_w2.res_im = cau_pkg::sat33(33'(r1_b) + 33'(r1_d));
            end
            cau_pkg::CMD_SUB: begin
                n_w2.res_re = cau_pkg::sat33(33'(r1_a) - 33'(r1_c));
                n_w2.res_im = cau_pkg::sat33(33'(r1_b) - 33'(r1_d));
            end
            cau_pkg::CMD_MUL: begin
                n_w2.res_re = cau_pkg::sat_mag(w_sm_mre[64], w_sm_mre[63:0] >> cau_pkg::FracBits);
                n_w2.res_im = cau_pkg::sat_mag(w_sm_mim[64], w_sm_mim[63:0] >> cau_pkg::FracBits);
            end
            cau_pkg::CMD_DIV: begin
                n_w2.is_div = 1'b1;
                n_w2.dz     = (r1_c == 32'sd0) && (r1_d == 32'sd0);
                n_w2.neg_re = w_sm_dre[64];
                n_w2.neg_im = w_sm_dim[64];
                // The numerators ride in the remainder fields until set-up.
                n_w2.rem_re = w_sm_dre[63:0];
                n_w2.rem_im = w_sm_dim[63:0];
                n_w2.den    = 64'(r1_cc) + 64'(r1_dd);
            end
            cau_pkg::CMD_CONJ: begin
                n_w2.res_re = r1_a;
                n_w2.res_im = cau_pkg::sat33(33'd0 - 33'(r1_b));
            end
            default: begin
            end
        endcase
    end

    // Divider set-up: the quotient fits QBits bits unless num >= den << OvfShift.
    assign w_num_re_x = {{cau_pkg::OvfShift{1'b0}}, 1'b0, r_w2.rem_re};
    assign w_num_im_x = {{cau_pkg::OvfShift{1'b0}}, 1'b0, r_w2.rem_im};
    assign w_den_x    = {1'b0, r_w2.den, {cau_pkg::OvfShift{1'b0}}};

    always_comb begin
        n_w3        = r_w2;
        n_w3.ovf_re = w_num_re_x >= w_den_x;
        n_w3.ovf_im = w_num_im_x >= w_den_x;
        n_w3.rem_re = r_w2.rem_re >> cau_pkg::OvfShift;
        n_w3.rem_im = r_w2.rem_im >> cau_pkg::OvfShift;
        n_w3.dvd_re = cau_pkg::QBits'(r_w2.rem_re << cau_pkg::FracBits);
        n_w3.dvd_im = cau_pkg::QBits'(r_w2.rem_im << cau_pkg::FracBits);
        n_w3.q_re   = '0;
        n_w3.q_im   = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_valid) begin
            r1_cmd <= i_cmd;
            r1_a   <= i_a_re;
            r1_b   <= i_a_im;
            r1_c   <= i_b_re;
            r1_d   <= i_b_im;
            r1_ac  <= w_ac;
            r1_bd  <= w_bd;
            r1_ad  <= w_ad;
            r1_bc  <= w_bc;
            r1_cc  <= w_cc;
            r1_dd  <= w_dd;
        end
        if (w_rdy2 && r_v1) r_w2 <= n_w2;
        if (w_rdy3 && r_v2) r_w3 <= n_w3;
    end

endmodule

[hdl/cau_div_cell.sv]
// One cell of the divider chain: one restoring step for both quotient parts.
// Depends on cau_pkg.
module cau_div_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  cau_pkg::t_div_word    i_word,
    output logic                  o_valid,
    input  logic                  i_ready,
    output cau_pkg::t_div_word    o_word
);

    logic               r_v;
    logic               w_rdy;
    cau_pkg::t_div_word r_word, n_word;
    logic [64:0]        w_pr_re, w_pr_im, w_den;

    assign w_rdy   = !r_v || i_ready;
    assign o_ready = w_rdy;
    assign o_valid = r_v;
    assign o_word  = r_word;

    assign w_den   = {1'b0, i_word.den};
    assign w_pr_re = {i_word.rem_re, i_word.dvd_re[cau_pkg::QBits-1]};
    assign w_pr_im = {i_word.rem_im, i_word.dvd_im[cau_pkg::QBits-1]};

    always_comb begin
        logic [64:0] d_re;
        logic [64:0] d_im;
        d_re          = w_pr_re - w_den;
        d_im          = w_pr_im - w_den;
        n_word        = i_word;
        n_word.dvd_re = {i_word.dvd_re[cau_pkg::QBits-2:0], 1'b0};
        n_word.dvd_im = {i_word.dvd_im[cau_pkg::QBits-2:0], 1'b0};
        if (w_pr_re >= w_den) begin
            n_word.rem_re = d_re[63:0];
            n_word.q_re   = {i_word.q_re[cau_pkg::QBits-2:0], 1'b1};
        end else begin
            n_word.rem_re = w_pr_re[63:0];
            n_word.q_re   = {i_word.q_re[cau_pkg::QBits-2:0], 1'b0};
        end
        if (w_pr_im >= w_den) begin
            n_word.rem_im = d_im[63:0];
            n_word.q_im   = {i_word.q_im[cau_pkg::QBits-2:0], 1'b1};
        end else begin
            n_word.rem_im = w_pr_im[63:0];
            n_word.q_im   = {i_word.q_im[cau_pkg::QBits-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_rdy) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy && i_valid) r_word <= n_word;
    end

endmodule

[hdl/cau_checker.sv]
// Port-level checks of the complex arithmetic unit, bound to the top level.
// Depends on complex_arithmetic_unit_top_assert.svh and complex_arithmetic_unit_top.
`include "complex_arithmetic_unit_top_assert.svh"

module cau_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_res_re,
    input logic [31:0] i_res_im,
    input logic        i_div_zero
);

    // A word still waiting at the output is neither withdrawn nor changed.
    `CAU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    `CAU_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_res_re) && $stable(i_res_im) && $stable(i_div_zero))
    // A division by zero magnitude always gives a zero result.
    `CAU_ASSERT_NOW(a_dz_zero, i_clk, i_rst_n, i_out_valid && i_div_zero, i_res_re == 32'd0 && i_res_im == 32'd0)
    // Reset empties the pipeline, so nothing is offered in the following cycle.
    `CAU_ASSERT_NEXT(a_rst_empty, i_clk, 1'b1, !i_rst_n, !i_out_valid)

endmodule

bind complex_arithmetic_unit_top cau_checker u_cau_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_res_re    (o_out.res_re),
    .i_res_im    (o_out.res_im),
    .i_div_zero  (o_out.div_zero)
);
